/* design/ndefc_pkg.sv */
// ----------------------------------------------------------------------------
// ndefc_pkg
// Shared types, class codes and fixed type-name table for the NDEF record
// type classifier.
// ----------------------------------------------------------------------------
package ndefc_pkg;

    // Record class codes
    localparam logic [3:0] CLASS_TEXT        = 4'd0;
    localparam logic [3:0] CLASS_URI         = 4'd1;
    localparam logic [3:0] CLASS_SMART_POST  = 4'd2;
    localparam logic [3:0] CLASS_HANDOVER    = 4'd3;
    localparam logic [3:0] CLASS_VCARD       = 4'd4;
    localparam logic [3:0] CLASS_WIFI        = 4'd5;
    localparam logic [3:0] CLASS_BLUETOOTH   = 4'd6;
    localparam logic [3:0] CLASS_ABS_URI     = 4'd7;
    localparam logic [3:0] CLASS_UNSUPPORTED = 4'd8;

    // Type name format codes
    localparam logic [2:0] TNF_EMPTY      = 3'd0;
    localparam logic [2:0] TNF_WELL_KNOWN = 3'd1;
    localparam logic [2:0] TNF_MEDIA      = 3'd2;
    localparam logic [2:0] TNF_ABS_URI    = 3'd3;
    localparam logic [2:0] TNF_EXTERNAL   = 3'd4;
    localparam logic [2:0] TNF_UNKNOWN    = 3'd5;
    localparam logic [2:0] TNF_UNCHANGED  = 3'd6;
    localparam logic [2:0] TNF_RESERVED   = 3'd7;

    // Flags byte bit positions
    localparam int FLAG_SR = 4;
    localparam int FLAG_IL = 3;

    // Header sizes up to the end of the payload length field
    localparam logic [2:0] HDR_SHORT = 3'd3;
    localparam logic [2:0] HDR_LONG  = 3'd6;

    // Fixed type names
    localparam int NAME_COUNT = 8;
    localparam int NAME_MAX   = 32;

    localparam logic [2:0] NM_T    = 3'd0;
    localparam logic [2:0] NM_U    = 3'd1;
    localparam logic [2:0] NM_SP   = 3'd2;
    localparam logic [2:0] NM_HS   = 3'd3;
    localparam logic [2:0] NM_XVC  = 3'd4;
    localparam logic [2:0] NM_VC   = 3'd5;
    localparam logic [2:0] NM_WIFI = 3'd6;
    localparam logic [2:0] NM_BT   = 3'd7;

    localparam logic [5:0] NAME_LEN [NAME_COUNT] = '{
        6'd1, 6'd1, 6'd2, 6'd2, 6'd12, 6'd10, 6'd23, 6'd32
    };

    // Each name is right-aligned: its last character sits in bits [7:0]
    localparam logic [8*NAME_MAX-1:0] NAME_TEXT [NAME_COUNT] = '{
        (8*NAME_MAX)'("T"),
        (8*NAME_MAX)'("U"),
        (8*NAME_MAX)'("Sp"),
        (8*NAME_MAX)'("Hs"),
        (8*NAME_MAX)'("text/x-vCard"),
        (8*NAME_MAX)'("text/vcard"),
        (8*NAME_MAX)'("application/vnd.wfa.wsc"),
        (8*NAME_MAX)'("application/vnd.bluetooth.ep.oob")
    };

    // Character i of fixed name k (valid for i below the name length)
    function automatic logic [7:0] name_char(input logic [2:0] k, input logic [4:0] i);
        logic [5:0] pos;
        pos = NAME_LEN[k] - 6'd1 - {1'b0, i};
        return NAME_TEXT[k][{pos[4:0], 3'b000} +: 8];
    endfunction

    // One result item
    typedef struct packed {
        logic [3:0]  record_class;
        logic [31:0] payload_length;
        logic [9:0]  payload_offset;
        logic        short_record;
        logic        id_present;
        logic [2:0]  name_format;
    } ndefc_result_t;

endpackage

/* design/ndefc_name_match.sv */
// ----------------------------------------------------------------------------
// ndefc_name_match
// Clears the match flag of every fixed name that disagrees with the type
// byte at the given index within the type field.
// ----------------------------------------------------------------------------
module ndefc_name_match (
    input  logic [8:0] type_idx,
    input  logic [7:0] data_byte,
    input  logic [7:0] match_in,
    output logic [7:0] match_out
);

    // Compare the byte against each name in parallel
    always_comb
    begin
        for (int k = 0; k < ndefc_pkg::NAME_COUNT; k++)
        begin
            if ((type_idx < {3'b000, ndefc_pkg::NAME_LEN[k]}) &&
                (ndefc_pkg::name_char(3'(k), type_idx[4:0]) == data_byte))
            begin
                match_out[k] = match_in[k];
            end
            else
            begin
                match_out[k] = 1'b0;
            end
        end
    end

endmodule

/* design/ndefc_parser.sv */
// ----------------------------------------------------------------------------
// ndefc_parser
// Record header state: tracks the byte position, captures header fields,
// runs the type-name match and forms the result on the last header or type byte.
// ----------------------------------------------------------------------------
module ndefc_parser (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [7:0]               data_byte,
    input  logic                     record_start,
    output logic                     emit,
    output ndefc_pkg::ndefc_result_t result
);

    logic [8:0]  pos_reg,   pos_next;
    logic [7:0]  flags_reg, flags_next;
    logic [7:0]  tlen_reg,  tlen_next;
    logic [31:0] acc_reg,   acc_next;
    logic [7:0]  idlen_reg, idlen_next;
    logic [7:0]  match_reg, match_next;
    logic        done_reg,  done_next;

    logic [2:0]  len_end;
    logic [2:0]  hdr;
    logic [8:0]  type_idx;
    logic [7:0]  match_upd;
    logic [9:0]  end_pos;
    logic        active;

    // Header layout from the flags byte
    assign len_end  = flags_reg[ndefc_pkg::FLAG_SR] ? ndefc_pkg::HDR_SHORT
                                                    : ndefc_pkg::HDR_LONG;
    assign hdr      = len_end + {2'b00, flags_reg[ndefc_pkg::FLAG_IL]};
    assign type_idx = pos_reg - {6'b0, hdr};
    assign active   = !record_start && !done_reg;

    ndefc_name_match u_name_match (
        .type_idx  (type_idx),
        .data_byte (data_byte),
        .match_in  (match_reg),
        .match_out (match_upd)
    );

    function automatic logic name_hit(input logic [7:0] m, input logic [7:0] tl,
                                      input logic [2:0] k);
        return m[k] && (tl == {2'b00, ndefc_pkg::NAME_LEN[k]});
    endfunction

    // Class from name format and surviving name matches
    function automatic logic [3:0] classify(input logic [2:0] tnf, input logic [7:0] m,
                                            input logic [7:0] tl);
        logic [3:0] c;
        c = ndefc_pkg::CLASS_UNSUPPORTED;
        case (tnf)
            ndefc_pkg::TNF_WELL_KNOWN:
            begin
                if (name_hit(m, tl, ndefc_pkg::NM_T))
                    c = ndefc_pkg::CLASS_TEXT;
                else if (name_hit(m, tl, ndefc_pkg::NM_U))
                    c = ndefc_pkg::CLASS_URI;
                else if (name_hit(m, tl, ndefc_pkg::NM_SP))
                    c = ndefc_pkg::CLASS_SMART_POST;
                else if (name_hit(m, tl, ndefc_pkg::NM_HS))
                    c = ndefc_pkg::CLASS_HANDOVER;
            end
            ndefc_pkg::TNF_MEDIA:
            begin
                if (name_hit(m, tl, ndefc_pkg::NM_XVC) || name_hit(m, tl, ndefc_pkg::NM_VC))
                    c = ndefc_pkg::CLASS_VCARD;
                else if (name_hit(m, tl, ndefc_pkg::NM_WIFI))
                    c = ndefc_pkg::CLASS_WIFI;
                else if (name_hit(m, tl, ndefc_pkg::NM_BT))
                    c = ndefc_pkg::CLASS_BLUETOOTH;
            end
            ndefc_pkg::TNF_ABS_URI:
                c = ndefc_pkg::CLASS_ABS_URI;
            default:
                c = ndefc_pkg::CLASS_UNSUPPORTED;
        endcase
        return c;
    endfunction

    // Field capture for the current byte
    always_comb
    begin
        tlen_next  = tlen_reg;
        acc_next   = acc_reg;
        idlen_next = idlen_reg;
        match_next = match_reg;
        if (pos_reg == 9'd1)
        begin
            tlen_next = data_byte;
        end
        else if (pos_reg < {6'b0, len_end})
        begin
            if (flags_reg[ndefc_pkg::FLAG_SR])
                acc_next = {24'b0, data_byte};
            else
                acc_next = {acc_reg[23:0], data_byte};
        end
        else if (pos_reg < {6'b0, hdr})
        begin
            idlen_next = data_byte;
        end
        else
        begin
            match_next = match_upd;
        end
    end

    // Last type byte reached, or last header byte when the type is empty
    assign end_pos = {7'b0, hdr} + {2'b00, tlen_next};
    assign emit    = active && (pos_reg >= 9'd2) && ({1'b0, pos_reg} + 10'd1 == end_pos);

    // Result fields
    always_comb
    begin
        result.record_class   = classify(flags_reg[2:0], match_next, tlen_next);
        result.payload_length = acc_next;
        result.payload_offset = end_pos + {2'b00, idlen_next};
        result.short_record   = flags_reg[ndefc_pkg::FLAG_SR];
        result.id_present     = flags_reg[ndefc_pkg::FLAG_IL];
        result.name_format    = flags_reg[2:0];
    end

    // Next state
    always_comb
    begin
        pos_next   = pos_reg;
        flags_next = flags_reg;
        done_next  = done_reg;
        if (record_start)
        begin
            pos_next   = 9'd1;
            flags_next = data_byte;
            done_next  = 1'b0;
        end
        else if (!done_reg)
        begin
            pos_next  = pos_reg + 9'd1;
            done_next = emit;
        end
    end

    // Advance state on each transfer out of the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            flags_reg <= '0;
            tlen_reg  <= '0;
            acc_reg   <= '0;
            idlen_reg <= '0;
            match_reg <= '1;
            done_reg  <= 1'b1;
        end
        else if (step)
        begin
            pos_reg   <= pos_next;
            flags_reg <= flags_next;
            done_reg  <= done_next;
            if (record_start)
            begin
                tlen_reg  <= '0;
                acc_reg   <= '0;
                idlen_reg <= '0;
                match_reg <= '1;
            end
            else if (!done_reg)
            begin
                tlen_reg  <= tlen_next;
                acc_reg   <= acc_next;
                idlen_reg <= idlen_next;
                match_reg <= match_next;
            end
        end
    end

endmodule

/* design/ndef_record_type_classifier.sv */
// ----------------------------------------------------------------------------
// ndef_record_type_classifier
// Result path: the byte that completes the header passes the input register,
// then header/match logic into the result register.
// Throughput: one byte per cycle; a held result stalls the input only when
// the byte in the input register completes another header.
// Reset: asynchronous, waits for a record start; no result pending.
// ----------------------------------------------------------------------------
module ndef_record_type_classifier (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        record_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  record_class,
    output logic [31:0] payload_length,
    output logic [9:0]  payload_offset,
    output logic        short_record,
    output logic        id_present,
    output logic [2:0]  name_format
);

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_start_reg;
    logic       s1_go;
    logic       emit;
    logic       out_valid_reg;

    ndefc_pkg::ndefc_result_t res;
    ndefc_pkg::ndefc_result_t res_reg;

    // Input stage moves on unless it carries a result and the output is held
    assign s1_go    = s1_valid_reg && (!out_valid_reg || out_ready || !emit);
    assign in_ready = !s1_valid_reg || s1_go;

    ndefc_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (s1_go),
        .data_byte    (s1_byte_reg),
        .record_start (s1_start_reg),
        .emit         (emit),
        .result       (res)
    );

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg  <= data_byte;
            s1_start_reg <= record_start;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_go && emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (s1_go && emit)
            res_reg <= res;
    end

    assign out_valid      = out_valid_reg;
    assign record_class   = res_reg.record_class;
    assign payload_length = res_reg.payload_length;
    assign payload_offset = res_reg.payload_offset;
    assign short_record   = res_reg.short_record;
    assign id_present     = res_reg.id_present;
    assign name_format    = res_reg.name_format;

    // Class code stays within the defined set
    a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> record_class <= ndefc_pkg::CLASS_UNSUPPORTED)
        else $error("record class out of range");

    // Offset covers at least the short header and at most the longest header
    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (payload_offset >= 10'd3) && (payload_offset <= 10'd517))
        else $error("payload offset out of range");

    // Short records carry a one-byte length
    a_short_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && short_record |-> payload_length[31:8] == 24'd0)
        else $error("short record length exceeds one byte");

    // Absolute URI class only for its name format
    a_abs_uri: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (record_class == ndefc_pkg::CLASS_ABS_URI)
            |-> name_format == ndefc_pkg::TNF_ABS_URI)
        else $error("absolute uri class with wrong name format");

    // A held input stage keeps its byte
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_byte_reg))
        else $error("input stage lost a held byte");

endmodule

/* dv/ndef_record_type_classifier_tb.sv */
// ----------------------------------------------------------------------------
// ndef_record_type_classifier_tb
// Self-checking bench for the NDEF record header classifier. Record bytes are
// driven over a valid/ready channel from a byte queue. A built-in header
// tracker predicts class, payload length, payload offset and flag fields.
// Every result transfer is compared against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ndef_record_type_classifier_tb;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 120;
    localparam int PHASE_BYTES = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        record_start = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  record_class;
    logic [31:0] payload_length;
    logic [9:0]  payload_offset;
    logic        short_record;
    logic        id_present;
    logic [2:0]  name_format;

    // Stimulus and expectation stores
    logic [8:0]               byte_q [$];
    logic [7:0]               type_buf [$];
    logic [7:0]               rec_buf [$];
    ndefc_pkg::ndefc_result_t pending_headers [$];
    ndefc_pkg::ndefc_result_t want;
    ndefc_pkg::ndefc_result_t got;
    logic [8:0]               tx_next;
    logic                     in_xfer = 1'b0;

    int tx_idle_pct = 29;
    int rx_idle_pct = 46;
    bit rx_hold_req = 1'b0;
    bit rx_hold_done = 1'b0;
    int rx_hold_left = 0;
    int stall_cnt = 0;
    int fail_cnt = 0;
    int byte_cnt = 0;
    int rec_cnt = 0;
    int checked_cnt = 0;
    int class_hits [9];
    int phase_end;

    // Mirror of the parser state
    logic [8:0]  hdr_pos;
    logic [7:0]  hdr_flags;
    logic [7:0]  hdr_type_len;
    logic [31:0] hdr_plen;
    logic [7:0]  hdr_id_len;
    logic [7:0]  hdr_match;
    logic        hdr_idle;

    ndef_record_type_classifier i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .record_start   (record_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .record_class   (record_class),
        .payload_length (payload_length),
        .payload_offset (payload_offset),
        .short_record   (short_record),
        .id_present     (id_present),
        .name_format    (name_format)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Fixed type names, indexed like the match bits
    function automatic string fixed_name(input int k);
        case (k)
            ndefc_pkg::NM_T:    return "T";
            ndefc_pkg::NM_U:    return "U";
            ndefc_pkg::NM_SP:   return "Sp";
            ndefc_pkg::NM_HS:   return "Hs";
            ndefc_pkg::NM_XVC:  return "text/x-vCard";
            ndefc_pkg::NM_VC:   return "text/vcard";
            ndefc_pkg::NM_WIFI: return "application/vnd.wfa.wsc";
            default:            return "application/vnd.bluetooth.ep.oob";
        endcase
    endfunction

    function automatic bit name_hit(input int k);
        string nm;
        nm = fixed_name(k);
        return hdr_match[k] && (hdr_type_len == nm.len());
    endfunction

    function automatic logic [3:0] classify_record();
        logic [2:0] tnf;
        tnf = hdr_flags[2:0];
        if (tnf == ndefc_pkg::TNF_WELL_KNOWN)
        begin
            if (name_hit(ndefc_pkg::NM_T))  return ndefc_pkg::CLASS_TEXT;
            if (name_hit(ndefc_pkg::NM_U))  return ndefc_pkg::CLASS_URI;
            if (name_hit(ndefc_pkg::NM_SP)) return ndefc_pkg::CLASS_SMART_POST;
            if (name_hit(ndefc_pkg::NM_HS)) return ndefc_pkg::CLASS_HANDOVER;
        end
        else if (tnf == ndefc_pkg::TNF_MEDIA)
        begin
            if (name_hit(ndefc_pkg::NM_XVC) || name_hit(ndefc_pkg::NM_VC))
                return ndefc_pkg::CLASS_VCARD;
            if (name_hit(ndefc_pkg::NM_WIFI)) return ndefc_pkg::CLASS_WIFI;
            if (name_hit(ndefc_pkg::NM_BT))   return ndefc_pkg::CLASS_BLUETOOTH;
        end
        else if (tnf == ndefc_pkg::TNF_ABS_URI)
        begin
            return ndefc_pkg::CLASS_ABS_URI;
        end
        return ndefc_pkg::CLASS_UNSUPPORTED;
    endfunction

    // Advance the header tracker by one byte; return 1 when a header completes
    function automatic bit track_header_byte(input logic [7:0] b, input logic st,
                                             output ndefc_pkg::ndefc_result_t r);
        int    p;
        int    len_end;
        int    hdr;
        int    i;
        int    k;
        string nm;
        r = '0;
        if (st)
        begin
            hdr_flags    = b;
            hdr_type_len = 8'd0;
            hdr_plen     = 32'd0;
            hdr_id_len   = 8'd0;
            hdr_match    = 8'hFF;
            hdr_idle     = 1'b0;
            hdr_pos      = 9'd1;
            return 1'b0;
        end
        if (hdr_idle)
            return 1'b0;

        p       = hdr_pos;
        len_end = hdr_flags[ndefc_pkg::FLAG_SR] ? ndefc_pkg::HDR_SHORT : ndefc_pkg::HDR_LONG;
        hdr     = len_end + (hdr_flags[ndefc_pkg::FLAG_IL] ? 1 : 0);

        if (p == 1)
            hdr_type_len = b;
        else if (p < len_end)
            hdr_plen = hdr_flags[ndefc_pkg::FLAG_SR] ? {24'd0, b} : {hdr_plen[23:0], b};
        else if (p < hdr)
            hdr_id_len = b;
        else
        begin
            // Drop every name that the type byte at this index rules out
            i = p - hdr;
            for (k = 0; k < ndefc_pkg::NAME_COUNT; k++)
            begin
                nm = fixed_name(k);
                if (i >= nm.len() || nm[i] != b)
                    hdr_match[k] = 1'b0;
            end
        end

        hdr_pos = 9'(p + 1);

        if (p >= 2 && p + 1 == hdr + hdr_type_len)
        begin
            hdr_idle         = 1'b1;
            r.record_class   = classify_record();
            r.payload_length = hdr_plen;
            r.payload_offset = 10'(hdr + hdr_type_len + hdr_id_len);
            r.short_record   = hdr_flags[ndefc_pkg::FLAG_SR];
            r.id_present     = hdr_flags[ndefc_pkg::FLAG_IL];
            r.name_format    = hdr_flags[2:0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Drive the next byte, hold it until the transfer
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_xfer)
        begin
            if (byte_q.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                tx_next = byte_q.pop_front();
                in_valid     <= 1'b1;
                record_start <= tx_next[8];
                data_byte    <= tx_next[7:0];
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Drive ready; a requested hold-off blocks results for a long stretch
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (rx_hold_left > 0)
        begin
            out_ready    <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end
        else if (rx_hold_req && !rx_hold_done)
        begin
            out_ready    <= 1'b0;
            rx_hold_left <= HOLD_CYCLES;
            rx_hold_done <= 1'b1;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Check result transfers, then predict from the input transfer
    always @(posedge clk)
    begin
        in_xfer <= rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_headers.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("%0t: result with nothing expected: class %0d len %h off %0d",
                             $time, record_class, payload_length, payload_offset);
            end
            else
            begin
                want = pending_headers.pop_front();
                checked_cnt++;
                class_hits[want.record_class]++;
                if (record_class !== want.record_class ||
                    payload_length !== want.payload_length ||
                    payload_offset !== want.payload_offset ||
                    short_record !== want.short_record ||
                    id_present !== want.id_present ||
                    name_format !== want.name_format)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                    begin
                        $write("%0t: mismatch exp/act class %0d/%0d len %h/%h ",
                               $time, want.record_class, record_class,
                               want.payload_length, payload_length);
                        $display("off %0d/%0d sr %b/%b il %b/%b tnf %0d/%0d",
                                 want.payload_offset, payload_offset,
                                 want.short_record, short_record,
                                 want.id_present, id_present,
                                 want.name_format, name_format);
                    end
                end
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            if (track_header_byte(data_byte, record_start, got))
                pending_headers.push_back(got);
        end
    end

    // Watchdog: end the run if no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cnt <= 0;
            else if (stall_cnt >= STALL_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
            else
                stall_cnt <= stall_cnt + 1;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic st);
        byte_q.push_back({st, b});
        byte_cnt++;
    endtask

    task automatic type_from_text(input string s);
        int i;
        type_buf.delete();
        for (i = 0; i < s.len(); i++)
            type_buf.push_back(s[i]);
    endtask

    task automatic type_random(input int n);
        type_buf.delete();
        repeat (n) type_buf.push_back(8'($urandom));
    endtask

    // Queue one record built from type_buf; cut > 0 truncates it
    task automatic emit_record(input logic [2:0] tnf, input bit sr, input bit il,
                               input logic [31:0] plen, input logic [7:0] idlen,
                               input int tail, input int cut);
        int n;
        int i;
        rec_buf.delete();
        rec_buf.push_back({3'($urandom_range(7)), sr, il, tnf});
        rec_buf.push_back(8'(type_buf.size()));
        if (sr)
            rec_buf.push_back(plen[7:0]);
        else
        begin
            rec_buf.push_back(plen[31:24]);
            rec_buf.push_back(plen[23:16]);
            rec_buf.push_back(plen[15:8]);
            rec_buf.push_back(plen[7:0]);
        end
        if (il)
            rec_buf.push_back(idlen);
        for (i = 0; i < type_buf.size(); i++)
            rec_buf.push_back(type_buf[i]);
        repeat (tail) rec_buf.push_back(8'($urandom));
        n = (cut > 0 && cut < rec_buf.size()) ? cut : rec_buf.size();
        for (i = 0; i < n; i++)
            push_byte(rec_buf[i], i == 0);
        rec_cnt++;
    endtask

    // Mostly well-formed records around the fixed names, some noise
    task automatic random_record();
        int          pick;
        int          k;
        int          pos;
        bit          sr;
        bit          il;
        logic [2:0]  tnf;
        logic [31:0] plen;
        logic [7:0]  idlen;
        pick = $urandom_range(99);
        k    = $urandom_range(7);
        tnf  = (k < 4) ? ndefc_pkg::TNF_WELL_KNOWN : ndefc_pkg::TNF_MEDIA;
        if (pick < 55)
        begin
            type_from_text(fixed_name(k));
            if ($urandom_range(9) == 0)
                tnf = 3'($urandom_range(7));
        end
        else if (pick < 72)
        begin
            // Near miss: flip one bit, append a byte or drop the last one
            type_from_text(fixed_name(k));
            pos = $urandom_range(type_buf.size() - 1);
            case ($urandom_range(2))
                0: type_buf[pos] = type_buf[pos] ^ (8'd1 << $urandom_range(7));
                1: type_buf.push_back(8'($urandom));
                default: type_buf.delete(type_buf.size() - 1);
            endcase
        end
        else if (pick < 82)
        begin
            tnf = ndefc_pkg::TNF_ABS_URI;
            type_random($urandom_range(8));
        end
        else if (pick < 98)
        begin
            tnf = 3'($urandom_range(7));
            type_random($urandom_range(20));
        end
        else
        begin
            tnf = 3'($urandom_range(7));
            type_random($urandom_range(64));
        end
        sr = ($urandom_range(99) < 65);
        il = ($urandom_range(99) < 40);
        case ($urandom_range(5))
            0: plen = 32'd0;
            1: plen = 32'hFFFF_FFFF;
            default: plen = $urandom;
        endcase
        idlen = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(6));
        emit_record(tnf, sr, il, plen, idlen, $urandom_range(3),
                    ($urandom_range(99) < 8) ? $urandom_range(6, 1) : 0);
        if ($urandom_range(99) < 6)
            repeat ($urandom_range(4, 1))
                push_byte(8'($urandom), ($urandom_range(3) == 0));
    endtask

    // Pause the sender until every byte is taken and every result is back
    task automatic wait_drained();
        while (byte_q.size() != 0 || in_valid || pending_headers.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        hdr_pos      = 9'd0;
        hdr_flags    = 8'd0;
        hdr_type_len = 8'd0;
        hdr_plen     = 32'd0;
        hdr_id_len   = 8'd0;
        hdr_match    = 8'hFF;
        hdr_idle     = 1'b1;
        foreach (class_hits[c])
            class_hits[c] = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: stray bytes before any record start
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        // Every fixed name with its own name format
        type_from_text("T");
        emit_record(ndefc_pkg::TNF_WELL_KNOWN, 1, 0, 32'h0000_0000, 8'd0, 2, 0);
        type_from_text("U");
        emit_record(ndefc_pkg::TNF_WELL_KNOWN, 1, 1, 32'h0000_00FF, 8'hFF, 3, 0);
        type_from_text("Sp");
        emit_record(ndefc_pkg::TNF_WELL_KNOWN, 0, 0, 32'hFFFF_FFFF, 8'd0, 1, 0);
        type_from_text("Hs");
        emit_record(ndefc_pkg::TNF_WELL_KNOWN, 0, 1, 32'h0102_0304, 8'd5, 0, 0);
        type_from_text("text/x-vCard");
        emit_record(ndefc_pkg::TNF_MEDIA, 1, 0, 32'd40, 8'd0, 0, 0);
        type_from_text("text/vcard");
        emit_record(ndefc_pkg::TNF_MEDIA, 0, 1, 32'h8000_0000, 8'd2, 0, 0);
        type_from_text("application/vnd.wfa.wsc");
        emit_record(ndefc_pkg::TNF_MEDIA, 0, 0, 32'h0000_0100, 8'd0, 2, 0);
        type_from_text("application/vnd.bluetooth.ep.oob");
        emit_record(ndefc_pkg::TNF_MEDIA, 1, 1, 32'd7, 8'd1, 0, 0);
        type_from_text("xyz");
        emit_record(ndefc_pkg::TNF_ABS_URI, 1, 0, 32'd3, 8'd0, 0, 0);
        // Empty type: result comes with the last header byte
        type_buf.delete();
        emit_record(ndefc_pkg::TNF_EMPTY, 1, 0, 32'd0, 8'd0, 1, 0);
        emit_record(ndefc_pkg::TNF_WELL_KNOWN, 1, 0, 32'd9, 8'd0, 0, 0);
        emit_record(ndefc_pkg::TNF_MEDIA, 0, 1, 32'd9, 8'd3, 0, 0);
        // Other name formats are unsupported even with a known name
        type_from_text("T");
        emit_record(ndefc_pkg::TNF_EXTERNAL, 1, 0, 32'd1, 8'd0, 0, 0);
        emit_record(ndefc_pkg::TNF_UNKNOWN, 1, 0, 32'd1, 8'd0, 0, 0);
        emit_record(ndefc_pkg::TNF_UNCHANGED, 0, 0, 32'd1, 8'd0, 0, 0);
        emit_record(ndefc_pkg::TNF_RESERVED, 1, 1, 32'd1, 8'd4, 0, 0);
        // Longer than a name, wrong case
        type_from_text("Tx");
        emit_record(ndefc_pkg::TNF_WELL_KNOWN, 1, 0, 32'd2, 8'd0, 0, 0);
        type_from_text("t");
        emit_record(ndefc_pkg::TNF_WELL_KNOWN, 1, 0, 32'd2, 8'd0, 0, 0);
        type_from_text("text/x-vcard");
        emit_record(ndefc_pkg::TNF_MEDIA, 1, 0, 32'd2, 8'd0, 0, 0);
        // Start in mid-record drops the open record
        type_from_text("Sp");
        emit_record(ndefc_pkg::TNF_WELL_KNOWN, 0, 1, 32'd77, 8'd9, 0, 4);
        emit_record(ndefc_pkg::TNF_WELL_KNOWN, 1, 0, 32'd77, 8'd0, 0, 0);
        // Wide offset: long header with ID length 255
        type_from_text("T");
        emit_record(ndefc_pkg::TNF_RESERVED, 0, 1, 32'hFFFF_FFFF, 8'hFF, 0, 0);

        // Phase 1: sender idles 29 %, receiver 46 %
        phase_end = byte_cnt + PHASE_BYTES;
        while (byte_cnt < phase_end)
            random_record();
        wait_drained();

        // Phase 2: swap the idle rates
        tx_idle_pct = 46;
        rx_idle_pct = 29;
        phase_end = byte_cnt + PHASE_BYTES;
        while (byte_cnt < phase_end)
            random_record();
        wait_drained();

        // Phase 3: no idling; first a long receiver hold-off under a burst
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 1'b1;
        type_from_text("T");
        repeat (12)
            emit_record(ndefc_pkg::TNF_WELL_KNOWN, 1, 0, $urandom, 8'd0, 0, 0);
        phase_end = byte_cnt + PHASE_BYTES;
        while (byte_cnt < phase_end)
            random_record();
        wait_drained();

        // Allow a late stray result to show up
        repeat (10) @(posedge clk);
        fail_cnt += pending_headers.size();

        $display("Sent %0d records in %0d bytes; %0d headers checked, %0d failures.",
                 rec_cnt, byte_cnt, checked_cnt, fail_cnt);
        $display("Class counts 0..8: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 class_hits[0], class_hits[1], class_hits[2], class_hits[3],
                 class_hits[4], class_hits[5], class_hits[6], class_hits[7],
                 class_hits[8]);
        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
